/* rtl/cluster_bounding_circle_obstacle_test_macros.svh */
// Assertion macros shared by the cluster obstacle test RTL.
`ifndef CLUSTER_BOUNDING_CIRCLE_OBSTACLE_TEST_MACROS_SVH
`define CLUSTER_BOUNDING_CIRCLE_OBSTACLE_TEST_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define CBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CBC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbc: next-cycle check failed");

`else

`define CBC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CBC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/cbc_pkg.sv */
package cbc_pkg;

   localparam int COORD_BITS  = 16;
   localparam int CFG_W       = 16;
   localparam int RADIUS_W    = 16;
   localparam int GAIN_W      = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic signed [COORD_BITS-1:0] COORD_MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic [CSR_INDEX_W-1:0] CSR_SAFETY_MARGIN      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_GAIN        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISTANCE_THRESHOLD = 2'd2;

   localparam logic [CFG_W-1:0]  SAFETY_MARGIN_RST      = 16'd512;
   localparam logic [GAIN_W-1:0] RADIUS_GAIN_RST        = 12'd0;
   localparam logic [CFG_W-1:0]  DISTANCE_THRESHOLD_RST = 16'd307;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_x;
      logic signed [COORD_BITS-1:0] center_y;
      logic [RADIUS_W-1:0]          circle_radius;
      logic                         obstacle_flag;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] lo_x;
      logic signed [COORD_BITS-1:0] hi_x;
      logic signed [COORD_BITS-1:0] lo_y;
      logic signed [COORD_BITS-1:0] hi_y;
   } box_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXTENT,
      ST_MUL_R,
      ST_RADIUS,
      ST_MUL_S,
      ST_MUL_X,
      ST_MUL_Y,
      ST_RESULT
   } state_type;

endpackage

/* rtl/cbc_box.sv */
// Running bounding box of the current cluster.
module cbc_box (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  update,
   input  logic                                  clear,
   input  logic signed [cbc_pkg::COORD_BITS-1:0] px,
   input  logic signed [cbc_pkg::COORD_BITS-1:0] py,
   output cbc_pkg::box_type                      box
);

   cbc_pkg::box_type box_ff;
   cbc_pkg::box_type box_in;

   always_comb begin
      box_in = box_ff;
      if (clear) begin
         box_in.lo_x = cbc_pkg::COORD_MAXV;
         box_in.hi_x = cbc_pkg::COORD_MINV;
         box_in.lo_y = cbc_pkg::COORD_MAXV;
         box_in.hi_y = cbc_pkg::COORD_MINV;
      end else if (update) begin
         if (px < box_ff.lo_x) box_in.lo_x = px;
         if (px > box_ff.hi_x) box_in.hi_x = px;
         if (py < box_ff.lo_y) box_in.lo_y = py;
         if (py > box_ff.hi_y) box_in.hi_y = py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff.lo_x <= cbc_pkg::COORD_MAXV;
         box_ff.hi_x <= cbc_pkg::COORD_MINV;
         box_ff.lo_y <= cbc_pkg::COORD_MAXV;
         box_ff.hi_y <= cbc_pkg::COORD_MINV;
      end else begin
         box_ff <= box_in;
      end
   end

   assign box = box_ff;

endmodule

/* rtl/cbc_mul.sv */
// Shared unsigned multiplier with registered product.
module cbc_mul #(
   parameter int OP_W = 18
) (
   input  logic              clock,
   input  logic              en,
   input  logic [OP_W-1:0]   a,
   input  logic [OP_W-1:0]   b,
   output logic [2*OP_W-1:0] prod
);

   logic [2*OP_W-1:0] prod_ff;
   logic [2*OP_W-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/cluster_bounding_circle_obstacle_test.sv */
// A result is offered once the transaction carrying the last point has been followed by
// the states EXTENT, MUL_R, RADIUS, MUL_S, MUL_X, MUL_Y and RESULT. Throughput: one point
//   per cycle while idle; a last point holds the input while the shared multiplier works
//   through radius, s^2, cx^2 and cy^2 in turn, longer while an earlier result still waits in the output register.
// Reset (synchronous, active high) restores the register defaults and an empty box.
`include "cluster_bounding_circle_obstacle_test_macros.svh"

module cluster_bounding_circle_obstacle_test #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cbc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cbc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [cbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbc_pkg::CFG_W-1:0]           csr_wdata
);

   localparam int C      = cbc_pkg::COORD_BITS;
   localparam int RW     = cbc_pkg::RADIUS_W;
   // 2^GAIN_FRAC_BITS + gain never needs more than this
   localparam int FAC_W  = ((GAIN_FRAC_BITS + 1 > cbc_pkg::GAIN_W) ?
                            GAIN_FRAC_BITS + 1 : cbc_pkg::GAIN_W) + 1;
   // margin + radius + threshold
   localparam int S_W    = cbc_pkg::CFG_W + 2;
   localparam int MW0    = (C > FAC_W) ? C : FAC_W;
   localparam int MUL_W  = (MW0 > S_W) ? MW0 : S_W;
   localparam int PROD_W = 2 * MUL_W;

   // Configuration registers
   logic [cbc_pkg::CFG_W-1:0]  margin_ff, margin_in;
   logic [cbc_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [cbc_pkg::CFG_W-1:0]  thresh_ff, thresh_in;

   // Sequencer
   cbc_pkg::state_type state_ff, state_in;

   // Datapath registers
   logic signed [C-1:0] cx_ff, cx_in;
   logic signed [C-1:0] cy_ff, cy_in;
   logic [C-1:0]        cxm_ff, cxm_in;
   logic [C-1:0]        cym_ff, cym_in;
   logic [C-1:0]        ext_ff, ext_in;
   logic [RW-1:0]       radius_ff, radius_in;
   logic [S_W-1:0]      s_ff, s_in;
   logic [PROD_W-1:0]   s2_ff, s2_in;
   logic [PROD_W-1:0]   d2_ff, d2_in;

   cbc_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Control decoded from the state
   logic ld_extent, ld_radius, ld_s2, ld_d2, in_result, mul_en;
   logic [MUL_W-1:0] mul_a, mul_b;
   logic rsp_load, box_clear, req_take;

   // Box and multiplier
   cbc_pkg::box_type  box;
   logic [PROD_W-1:0] prod;

   logic signed [C:0]  sum_x, sum_y;
   logic [C:0]         diff_x, diff_y;
   logic signed [C-1:0] cx_new, cy_new;
   logic [FAC_W-1:0]   factor;
   logic [PROD_W-1:0]  rad_full;
   logic [RW-1:0]      rad_sat;
   logic [PROD_W:0]    d2_sum;

   assign req_take = req_valid && req_ready;

   cbc_box u_box (
      .clock  (clock),
      .reset  (reset),
      .update (req_take),
      .clear  (box_clear),
      .px     (req_payload.point_x),
      .py     (req_payload.point_y),
      .box    (box)
   );

   cbc_mul #(.OP_W(MUL_W)) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Configuration writes; an unknown index is dropped
   always_comb begin
      margin_in = margin_ff;
      gain_in   = gain_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            cbc_pkg::CSR_SAFETY_MARGIN:      margin_in = csr_wdata;
            cbc_pkg::CSR_RADIUS_GAIN:        gain_in   = csr_wdata[cbc_pkg::GAIN_W-1:0];
            cbc_pkg::CSR_DISTANCE_THRESHOLD: thresh_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbc_pkg::ST_IDLE: begin
            if (req_take && req_payload.last_point) state_in = cbc_pkg::ST_EXTENT;
         end
         cbc_pkg::ST_EXTENT: state_in = cbc_pkg::ST_MUL_R;
         cbc_pkg::ST_MUL_R:  state_in = cbc_pkg::ST_RADIUS;
         cbc_pkg::ST_RADIUS: state_in = cbc_pkg::ST_MUL_S;
         cbc_pkg::ST_MUL_S:  state_in = cbc_pkg::ST_MUL_X;
         cbc_pkg::ST_MUL_X:  state_in = cbc_pkg::ST_MUL_Y;
         cbc_pkg::ST_MUL_Y:  state_in = cbc_pkg::ST_RESULT;
         cbc_pkg::ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) state_in = cbc_pkg::ST_IDLE;
         end
         default: state_in = cbc_pkg::ST_IDLE;
      endcase
   end

   assign factor = (FAC_W'(1) << GAIN_FRAC_BITS) + FAC_W'(gain_ff);

   // Sequencer outputs: steer the shared multiplier and the loads
   always_comb begin
      req_ready = 1'b0;
      ld_extent = 1'b0;
      ld_radius = 1'b0;
      ld_s2     = 1'b0;
      ld_d2     = 1'b0;
      in_result = 1'b0;
      mul_en    = 1'b0;
      mul_a     = MUL_W'(s_ff);
      mul_b     = MUL_W'(s_ff);
      unique case (state_ff)
         cbc_pkg::ST_IDLE:   req_ready = 1'b1;
         cbc_pkg::ST_EXTENT: ld_extent = 1'b1;
         cbc_pkg::ST_MUL_R: begin
            mul_en = 1'b1;
            mul_a  = MUL_W'(ext_ff);
            mul_b  = MUL_W'(factor);
         end
         cbc_pkg::ST_RADIUS: ld_radius = 1'b1;
         cbc_pkg::ST_MUL_S:  mul_en = 1'b1;
         cbc_pkg::ST_MUL_X: begin
            ld_s2  = 1'b1;
            mul_en = 1'b1;
            mul_a  = MUL_W'(cxm_ff);
            mul_b  = MUL_W'(cxm_ff);
         end
         cbc_pkg::ST_MUL_Y: begin
            ld_d2  = 1'b1;
            mul_en = 1'b1;
            mul_a  = MUL_W'(cym_ff);
            mul_b  = MUL_W'(cym_ff);
         end
         cbc_pkg::ST_RESULT: in_result = 1'b1;
         default: ;
      endcase
   end

   assign rsp_load  = in_result && (!rsp_valid_ff || rsp_ready);
   assign box_clear = rsp_load;

   // Box centre (floor of half the sum) and extents
   assign sum_x  = {box.hi_x[C-1], box.hi_x} + {box.lo_x[C-1], box.lo_x};
   assign sum_y  = {box.hi_y[C-1], box.hi_y} + {box.lo_y[C-1], box.lo_y};
   assign cx_new = sum_x[C:1];
   assign cy_new = sum_y[C:1];
   assign diff_x = {box.hi_x[C-1], box.hi_x} - {box.lo_x[C-1], box.lo_x};
   assign diff_y = {box.hi_y[C-1], box.hi_y} - {box.lo_y[C-1], box.lo_y};

   // Radius: drop the fraction and the halving, then saturate
   assign rad_full = prod >> (GAIN_FRAC_BITS + 1);
   assign rad_sat  = (|rad_full[PROD_W-1:RW]) ? {RW{1'b1}} : rad_full[RW-1:0];

   assign d2_sum = {1'b0, d2_ff} + {1'b0, prod};

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cxm_in    = cxm_ff;
      cym_in    = cym_ff;
      ext_in    = ext_ff;
      radius_in = radius_ff;
      s_in      = s_ff;
      s2_in     = s2_ff;
      d2_in     = d2_ff;
      rsp_in    = rsp_ff;
      if (ld_extent) begin
         cx_in  = cx_new;
         cy_in  = cy_new;
         cxm_in = cx_new[C-1] ? C'(-cx_new) : C'(cx_new);
         cym_in = cy_new[C-1] ? C'(-cy_new) : C'(cy_new);
         ext_in = (diff_x[C-1:0] > diff_y[C-1:0]) ? diff_x[C-1:0] : diff_y[C-1:0];
      end
      if (ld_radius) begin
         radius_in = rad_sat;
         s_in      = S_W'(margin_ff) + S_W'(rad_sat) + S_W'(thresh_ff);
      end
      if (ld_s2) s2_in = prod;
      if (ld_d2) d2_in = prod;
      if (rsp_load) begin
         rsp_in.center_x      = cx_ff;
         rsp_in.center_y      = cy_ff;
         rsp_in.circle_radius = radius_ff;
         rsp_in.obstacle_flag = d2_sum < {1'b0, s2_ff};
      end
   end

   // Output register: fill on a finished cluster, drain on the rsp transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         margin_ff    <= cbc_pkg::SAFETY_MARGIN_RST;
         gain_ff      <= cbc_pkg::RADIUS_GAIN_RST;
         thresh_ff    <= cbc_pkg::DISTANCE_THRESHOLD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         margin_ff    <= margin_in;
         gain_ff      <= gain_in;
         thresh_ff    <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cxm_ff    <= cxm_in;
      cym_ff    <= cym_in;
      ext_ff    <= ext_in;
      radius_ff <= radius_in;
      s_ff      <= s_in;
      s2_ff     <= s2_in;
      d2_ff     <= d2_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A last point starts the arithmetic sequence
   `CBC_ASSERT_NXT(a_last_starts, clock, reset, req_take && req_payload.last_point, state_ff == cbc_pkg::ST_EXTENT)
   // A finished cluster lands in the output register and frees the input
   `CBC_ASSERT_NXT(a_result_loads, clock, reset, rsp_load, rsp_valid_ff && state_ff == cbc_pkg::ST_IDLE)
   // The box is empty again once a result has been loaded
   `CBC_ASSERT_NXT(a_box_cleared, clock, reset, rsp_load, box.lo_x == cbc_pkg::COORD_MAXV && box.hi_y == cbc_pkg::COORD_MINV)
   // No point is taken while the sequence runs
   `CBC_ASSERT_IMP(a_busy_blocks, clock, reset, state_ff != cbc_pkg::ST_IDLE, !req_ready)

endmodule

/* sim/cluster_circle_checker.sv */
`timescale 1ns / 100ps

module cluster_circle_checker #(
   parameter int GAIN_FRAC = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cbc_pkg::req_type                    req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cbc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [cbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbc_pkg::CFG_W-1:0]           csr_wdata,
   output int                                  mismatches,
   output int                                  awaited
);

   localparam longint RADIUS_CAP = 65535;
   localparam cbc_pkg::box_type EMPTY_BOX = '{lo_x: cbc_pkg::COORD_MAXV,
                                              hi_x: cbc_pkg::COORD_MINV,
                                              lo_y: cbc_pkg::COORD_MAXV,
                                              hi_y: cbc_pkg::COORD_MINV};

   logic [cbc_pkg::CFG_W-1:0]  margin_reg;
   logic [cbc_pkg::GAIN_W-1:0] gain_reg;
   logic [cbc_pkg::CFG_W-1:0]  threshold_reg;
   cbc_pkg::box_type           cluster_box;
   cbc_pkg::rsp_type           circles_due[$];

   task automatic flag_mismatch(input string what);
      $display("%0t checker: %s", $time, what);
      mismatches++;
   endtask

   // Centre, scaled radius and clearance test for a closed bounding box.
   function automatic cbc_pkg::rsp_type enclose_box(input cbc_pkg::box_type b);
      longint           mid_x, mid_y, span, span_y, radius, reach;
      cbc_pkg::rsp_type circle;
      mid_x  = (longint'(b.hi_x) + longint'(b.lo_x)) >>> 1;
      mid_y  = (longint'(b.hi_y) + longint'(b.lo_y)) >>> 1;
      span   = longint'(b.hi_x) - longint'(b.lo_x);
      span_y = longint'(b.hi_y) - longint'(b.lo_y);
      if (span_y > span)
         span = span_y;
      radius = (span * ((longint'(1) << GAIN_FRAC) + longint'(gain_reg))) >>> (GAIN_FRAC + 1);
      if (radius > RADIUS_CAP)
         radius = RADIUS_CAP;
      reach  = longint'(margin_reg) + radius + longint'(threshold_reg);
      circle.center_x      = mid_x[cbc_pkg::COORD_BITS-1:0];
      circle.center_y      = mid_y[cbc_pkg::COORD_BITS-1:0];
      circle.circle_radius = radius[cbc_pkg::RADIUS_W-1:0];
      circle.obstacle_flag = (mid_x * mid_x + mid_y * mid_y) < reach * reach;
      return circle;
   endfunction

   always @(posedge clock) begin : watch
      cbc_pkg::rsp_type want;
      if (reset) begin
         margin_reg    = cbc_pkg::SAFETY_MARGIN_RST;
         gain_reg      = cbc_pkg::RADIUS_GAIN_RST;
         threshold_reg = cbc_pkg::DISTANCE_THRESHOLD_RST;
         cluster_box   = EMPTY_BOX;
         circles_due.delete();
         mismatches    = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (circles_due.size() == 0) begin
               flag_mismatch("result with no cluster outstanding");
            end else begin
               want = circles_due.pop_front();
               if (rsp_payload.center_x !== want.center_x)
                  flag_mismatch($sformatf("center_x got %0d want %0d",
                                          rsp_payload.center_x, want.center_x));
               if (rsp_payload.center_y !== want.center_y)
                  flag_mismatch($sformatf("center_y got %0d want %0d",
                                          rsp_payload.center_y, want.center_y));
               if (rsp_payload.circle_radius !== want.circle_radius)
                  flag_mismatch($sformatf("circle_radius got %0d want %0d",
                                          rsp_payload.circle_radius, want.circle_radius));
               if (rsp_payload.obstacle_flag !== want.obstacle_flag)
                  flag_mismatch($sformatf("obstacle_flag got %b want %b",
                                          rsp_payload.obstacle_flag, want.obstacle_flag));
            end
         end
         if (csr_we) begin
            case (csr_index)
               cbc_pkg::CSR_SAFETY_MARGIN:      margin_reg    = csr_wdata;
               cbc_pkg::CSR_RADIUS_GAIN:        gain_reg      = csr_wdata[cbc_pkg::GAIN_W-1:0];
               cbc_pkg::CSR_DISTANCE_THRESHOLD: threshold_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_payload.point_x < cluster_box.lo_x) cluster_box.lo_x = req_payload.point_x;
            if (req_payload.point_x > cluster_box.hi_x) cluster_box.hi_x = req_payload.point_x;
            if (req_payload.point_y < cluster_box.lo_y) cluster_box.lo_y = req_payload.point_y;
            if (req_payload.point_y > cluster_box.hi_y) cluster_box.hi_y = req_payload.point_y;
            if (req_payload.last_point) begin
               circles_due.insert(circles_due.size(), enclose_box(cluster_box));
               cluster_box = EMPTY_BOX;
            end
         end
      end
      awaited = circles_due.size();
   end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int COORD_BITS   = cbc_pkg::COORD_BITS;
   localparam int CFG_W        = cbc_pkg::CFG_W;
   localparam int GAIN_W       = cbc_pkg::GAIN_W;
   localparam int CSR_INDEX_W  = cbc_pkg::CSR_INDEX_W;
   localparam int GAIN_FRAC    = 8;
   localparam int RESULT_DELAY = 7;       // last point to result
   localparam int HOLD_OFF     = 300;     // receiver stall long enough to back up the input
   localparam int CYCLE_LIMIT  = 600000;
   // Index with no register behind it; writes to it must leave every register alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   cbc_pkg::req_type       req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   cbc_pkg::rsp_type       rsp_payload;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   int mismatches;
   int awaited;
   int cycles = 0;
   bit calm;      // both sides stop idling while set
   bit squeeze;   // ask the receiver for its one long hold-off

   cluster_bounding_circle_obstacle_test #(
      .GAIN_FRAC_BITS(GAIN_FRAC)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   cluster_circle_checker #(
      .GAIN_FRAC(GAIN_FRAC)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .awaited     (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: abandon the run if the handshakes ever lock up.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random back-pressure, drop it entirely while calm, and serve one long
   // hold-off when asked. The hold-off is counted here so that the sender keeps offering
   // points meanwhile and the block has to stall its input.
   initial begin : receiver
      bit squeezed;
      squeezed  = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end
         rsp_ready <= calm || $urandom_range(99) >= 28;
      end
   end

   // Write one register; only called while the block has nothing in flight.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Offer one point and hold it until the block takes it. Idle cycles go in before the
   // point is raised, never between a lowering and raising in the same step.
   task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                             input logic signed [COORD_BITS-1:0] py,
                             input logic                         closes);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_payload <= '{point_x: px, point_y: py, last_point: closes};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // One cluster scattered around a centre; coordinates simply wrap at the 16-bit edges.
   task automatic send_cluster(input int count, input int cx, input int cy, input int spread);
      for (int k = 0; k < count; k++)
         send_point(COORD_BITS'(cx + int'($urandom_range(2 * spread)) - spread),
                    COORD_BITS'(cy + int'($urandom_range(2 * spread)) - spread),
                    k == count - 1);
   endtask

   // Stop offering, wait for every outstanding circle, then give the block time to go idle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (2 * RESULT_DELAY) @(negedge clock);
   endtask

   // Pick a setting per register, leaning on the extremes; junk the bits above the gain.
   task automatic program_random();
      logic [CFG_W-1:0]  margin;
      logic [GAIN_W-1:0] gain;
      logic [CFG_W-1:0]  thresh;
      case ($urandom_range(3))
         0:       margin = '0;
         1:       margin = '1;
         2:       margin = CFG_W'($urandom_range(3000));
         default: margin = CFG_W'($urandom);
      endcase
      case ($urandom_range(3))
         0:       gain = '0;
         1:       gain = '1;
         2:       gain = GAIN_W'($urandom_range(300));
         default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(3))
         0:       thresh = '0;
         1:       thresh = '1;
         2:       thresh = CFG_W'($urandom_range(3000));
         default: thresh = CFG_W'($urandom);
      endcase
      write_reg(cbc_pkg::CSR_SAFETY_MARGIN, margin);
      write_reg(cbc_pkg::CSR_RADIUS_GAIN, {(CFG_W - GAIN_W)'($urandom), gain});
      write_reg(cbc_pkg::CSR_DISTANCE_THRESHOLD, thresh);
   endtask

   // Clusters of mixed size and shape: mostly small, many near the sensor, some spread
   // over the whole plane, some pushed against the corners.
   task automatic random_clusters(input int total);
      int sent;
      int count;
      int cx;
      int cy;
      int spread;
      int pick;
      sent = 0;
      while (sent < total) begin
         pick  = $urandom_range(99);
         count = pick < 10 ? 1 : pick < 75 ? $urandom_range(12, 2) : $urandom_range(40, 13);
         pick  = $urandom_range(99);
         if (pick < 40) begin
            cx = int'($urandom_range(8000)) - 4000;
            cy = int'($urandom_range(8000)) - 4000;
         end else if (pick < 80) begin
            cx = int'($urandom_range(65535)) - 32768;
            cy = int'($urandom_range(65535)) - 32768;
         end else begin
            cx = $urandom_range(1) ? 32000 : -32000;
            cy = $urandom_range(1) ? 32000 : -32000;
         end
         pick   = $urandom_range(99);
         spread = pick < 50 ? $urandom_range(600) : pick < 85 ? $urandom_range(4000) : 32767;
         send_cluster(count, cx, cy, spread);
         sent += count;
      end
   endtask

   initial begin : stimulus
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = cbc_pkg::CSR_SAFETY_MARGIN;
      csr_wdata   = '0;
      reset       = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings. Single points at the origin and in a corner, the full-plane box,
      // a centre sum that is odd in y and negative in x, and a cluster far from the sensor.
      send_point(16'sd0, 16'sd0, 1'b1);
      send_point(cbc_pkg::COORD_MAXV, cbc_pkg::COORD_MINV, 1'b1);
      send_point(cbc_pkg::COORD_MINV, cbc_pkg::COORD_MINV, 1'b0);
      send_point(cbc_pkg::COORD_MAXV, cbc_pkg::COORD_MAXV, 1'b1);
      send_point(-16'sd3, 16'sd5, 1'b0);
      send_point(16'sd0, -16'sd2, 1'b0);
      send_point(16'sd1, 16'sd1, 1'b1);
      send_point(16'sd30000, 16'sd30000, 1'b1);
      send_point(cbc_pkg::COORD_MINV, cbc_pkg::COORD_MAXV, 1'b0);
      send_point(cbc_pkg::COORD_MAXV, cbc_pkg::COORD_MINV, 1'b1);
      settle();

      // Everything at its top: the radius saturates and the clearance is at its widest.
      // The spare index must be ignored.
      write_reg(cbc_pkg::CSR_SAFETY_MARGIN, '1);
      write_reg(cbc_pkg::CSR_RADIUS_GAIN, '1);
      write_reg(cbc_pkg::CSR_DISTANCE_THRESHOLD, '1);
      write_reg(CSR_SPARE, CFG_W'($urandom));
      send_point(cbc_pkg::COORD_MINV, 16'sd0, 1'b0);
      send_point(cbc_pkg::COORD_MAXV, 16'sd0, 1'b1);
      send_point(16'sd0, 16'sd0, 1'b1);
      send_point(cbc_pkg::COORD_MAXV, cbc_pkg::COORD_MAXV, 1'b1);
      settle();

      // Everything at zero: nothing can be closer than a zero clearance.
      write_reg(cbc_pkg::CSR_SAFETY_MARGIN, '0);
      write_reg(cbc_pkg::CSR_RADIUS_GAIN, '0);
      write_reg(cbc_pkg::CSR_DISTANCE_THRESHOLD, '0);
      send_point(16'sd0, 16'sd0, 1'b1);
      send_point(16'sd1, 16'sd0, 1'b1);
      send_point(-16'sd1, -16'sd1, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
      settle();

      // Random phases, each under fresh settings. One phase carries the long receiver
      // hold-off, another runs with no idling on either side.
      for (int phase = 0; phase < 5; phase++) begin
         program_random();
         if (phase == 1)
            squeeze <= 1'b1;
         calm <= (phase == 3);
         random_clusters(390);
         settle();
      end

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/cbc_pkg.sv
rtl/cbc_box.sv
rtl/cbc_mul.sv
rtl/cluster_bounding_circle_obstacle_test.sv
sim/cluster_circle_checker.sv
sim/tb_top.sv
